/* rtl/swa_pkg.sv */
// Shared constants and types for the sliding window aggregate block.
package swa_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int DATA_W         = 32;
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 5'd16;

    typedef enum logic [1:0] {
        MODE_AVG = 2'd0,
        MODE_MAX = 2'd1,
        MODE_MIN = 2'd2,
        MODE_SUM = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_DONE
    } state_t;

endpackage

/* rtl/sliding_window_aggregate_core.sv */
// Sliding window sum / average / max / min over a circular sample store.
// Steps: the input transfer stores the sample, the walk reads the held samples (held =
// samples in window) newest first, average runs the serial divider (SUM_W = 33 + log2
// WINDOW_MAX quotient bits). One item at a time: the next input waits for the result,
// held back by the one-read-per-cycle walk, the 1-bit divider and output stalls.
// Reset: empty window, window_len = 16, mode = sum; the store itself is not cleared.
module sliding_window_aggregate_core
    import swa_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,    // [31:0] sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,    // [31:0] result
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = DATA_W + 1 + $clog2(WINDOW_MAX);

    logic [DATA_W-1:0] mem [WINDOW_MAX];
    logic [DATA_W-1:0] rdata_reg;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  window_len_reg;
    mode_t             mode_reg;
    mode_t             op_reg, op_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     held_reg, held_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic [CW-1:0]     recv_reg, recv_next;
    logic              rvld_reg, rvld_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [DATA_W-1:0] best_reg, best_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              accept;
    logic              walk_last;
    logic [CW-1:0]     len_eff;
    logic [CW-1:0]     fill_inc;
    logic [SUM_W-1:0]  dividend;
    logic [SUM_W-1:0]  quotient;
    logic              div_done;
    logic [DATA_W-1:0] avg_res;
    logic [DATA_W-1:0] res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign walk_last = rvld_reg && (CW'(recv_reg + 1'b1) == held_reg);

    // window length clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (window_len_reg == '0)
            len_eff = CW'(1);
        else if (32'(window_len_reg) > 32'(WINDOW_MAX))
            len_eff = CW'(WINDOW_MAX);
        else
            len_eff = CW'(window_len_reg);
        fill_inc = (32'(fill_reg) < 32'(WINDOW_MAX)) ? CW'(fill_reg + 1'b1) : fill_reg;
    end

    assign dividend = acc_reg[SUM_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign avg_res  = acc_reg[SUM_W-1] ? (~quotient[DATA_W-1:0] + 1'b1)
                                       : quotient[DATA_W-1:0];

    always_comb
    begin
        case (op_reg)
            MODE_AVG: res = avg_res;
            MODE_MAX: res = best_reg;
            MODE_MIN: res = best_reg;
            MODE_SUM: res = acc_reg[DATA_W-1:0];
            default:  res = acc_reg[DATA_W-1:0];
        endcase
    end

    swa_div #(
        .SUM_W (SUM_W),
        .DIV_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIVGO),
        .dividend (dividend),
        .divisor  (held_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_last)
                    state_next = (op_reg == MODE_AVG) ? ST_DIVGO : ST_DONE;
            end
            ST_DIVGO:
                state_next = ST_DIVWAIT;
            ST_DIVWAIT:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        wp_next       = wp_reg;
        rd_addr_next  = rd_addr_reg;
        fill_next     = fill_reg;
        held_next     = held_reg;
        iss_next      = iss_reg;
        recv_next     = recv_reg;
        op_next       = op_reg;
        acc_next      = acc_reg;
        best_next     = best_reg;
        rvld_next     = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wp_next      = (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : AW'(wp_reg + 1'b1);
                    rd_addr_next = wp_reg;
                    fill_next    = fill_inc;
                    held_next    = (fill_inc < len_eff) ? fill_inc : len_eff;
                    op_next      = mode_reg;
                    iss_next     = '0;
                    recv_next    = '0;
                    acc_next     = '0;
                end
            end
            ST_WALK:
            begin
                if (iss_reg < held_reg)
                begin
                    rvld_next    = 1'b1;
                    iss_next     = CW'(iss_reg + 1'b1);
                    rd_addr_next = (rd_addr_reg == '0) ? AW'(WINDOW_MAX - 1)
                                                       : AW'(rd_addr_reg - 1'b1);
                end
                if (rvld_reg)
                begin
                    acc_next  = acc_reg + {{(SUM_W-DATA_W){rdata_reg[DATA_W-1]}}, rdata_reg};
                    recv_next = CW'(recv_reg + 1'b1);
                    if (recv_reg == '0)
                        best_next = rdata_reg;
                    else if (op_reg == MODE_MAX && $signed(rdata_reg) > $signed(best_reg))
                        best_next = rdata_reg;
                    else if (op_reg == MODE_MIN && $signed(rdata_reg) < $signed(best_reg))
                        best_next = rdata_reg;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= WINDOW_LEN_RST;
            mode_reg       <= MODE_SUM;
            wp_reg         <= '0;
            fill_reg       <= '0;
            rvld_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            rvld_reg     <= rvld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we && cfg_addr == REG_WINDOW_LEN)
                window_len_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == REG_MODE)
                mode_reg <= mode_t'(cfg_wdata[1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        held_reg    <= held_next;
        iss_reg     <= iss_next;
        recv_reg    <= recv_next;
        op_reg      <= op_next;
        acc_reg     <= acc_next;
        best_reg    <= best_next;
        m_tdata_reg <= m_tdata_next;
    end

    // sample store: newest written at wp, walked backwards from there
    always_ff @(posedge clk)
    begin
        if (accept)
            mem[wp_reg] <= s_tdata;
        rdata_reg <= mem[rd_addr_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/swa_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module swa_div
    import swa_pkg::*;
#(
    parameter int SUM_W = 40,
    parameter int DIV_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int KW = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [KW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[SUM_W-1]};
        trial     = rem_sh - {1'b0, divisor};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, divisor})
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == KW'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* bench/swa_checker.sv */
// Checker for the sliding window aggregate core: predicts every result and compares transfers.
module swa_checker
    import swa_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,    // [31:0] sample
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [DATA_W-1:0]    m_tdata,    // [31:0] result
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   outstanding,
    output int                   samples_seen,
    output int                   results_seen
);

    // shadow of the block: newest sample at index 0
    logic [DATA_W-1:0] history [WINDOW_MAX];
    int                fill_level;
    logic [CFG_W-1:0]  span_reg;
    mode_t             op_reg;

    logic [DATA_W-1:0] pending_aggregates [$];

    function automatic logic [DATA_W-1:0] aggregate_window();
        int                       span;
        int                       held;
        int                       i;
        longint                   total;
        longint                   quot;
        logic signed [DATA_W-1:0] best;
        logic signed [DATA_W-1:0] v;
        span = (span_reg == 0) ? 1 : ((span_reg > WINDOW_MAX) ? WINDOW_MAX : span_reg);
        held = (fill_level < span) ? fill_level : span;
        if (held < 1)
            held = 1;
        total = 0;
        best  = history[0];
        for (i = 0; i < held; i++)
        begin
            v = history[i];
            total = total + v;
            if (op_reg == MODE_MAX && v > best)
                best = v;
            if (op_reg == MODE_MIN && v < best)
                best = v;
        end
        case (op_reg)
            MODE_SUM: return total[DATA_W-1:0];
            MODE_AVG:
            begin
                // 64-bit signed divide truncates toward zero
                quot = total / held;
                return quot[DATA_W-1:0];
            end
            default:  return best;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int                i;
        logic [DATA_W-1:0] want;
        if (!rst_n)
        begin
            for (i = 0; i < WINDOW_MAX; i++)
                history[i] = '0;
            fill_level   = 0;
            span_reg     = WINDOW_LEN_RST;
            op_reg       = MODE_SUM;
            pending_aggregates.delete();
            mismatches   = 0;
            outstanding  = 0;
            samples_seen = 0;
            results_seen = 0;
        end
        else
        begin
            // a result always leaves after its own sample is taken, so check results first
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_aggregates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: unexpected transfer, data %h",
                                 results_seen, m_tdata);
                end
                else
                begin
                    want = pending_aggregates.pop_front();
                    if (m_tdata !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %h got %h",
                                     results_seen, want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                samples_seen++;
                for (i = WINDOW_MAX - 1; i > 0; i--)
                    history[i] = history[i-1];
                history[0] = s_tdata;
                if (fill_level < WINDOW_MAX)
                    fill_level++;
                pending_aggregates.push_back(aggregate_window());
            end
            if (cfg_we)
            begin
                if (cfg_addr == REG_WINDOW_LEN)
                    span_reg = cfg_wdata;
                else if (cfg_addr == REG_MODE)
                    op_reg = mode_t'(cfg_wdata[1:0]);
            end
            outstanding = pending_aggregates.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// Testbench top for the sliding window aggregate core: clock, reset, stimulus and verdict.
module tb_top
    import swa_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;    // [31:0] sample
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;    // [31:0] result
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    int fail_count;
    int in_flight;
    int n_samples;
    int n_results;
    int cycle_count = 0;
    int settings_used = 0;

    bit sink_stall_en = 1'b0;
    bit sink_hold_req = 1'b0;
    bit src_gap_en    = 1'b0;

    sliding_window_aggregate_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    swa_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (fail_count),
        .outstanding  (in_flight),
        .samples_seen (n_samples),
        .results_seen (n_results)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count, in_flight);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        else if (r < 8)
            return $urandom_range(0, 64) - 32;
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0001;
            default: return 32'h7FFF_FFFE;
        endcase
    endfunction

    // output side: random stalls, plus one long hold-off on request
    initial
    begin : sink
        int n;
        m_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                n = HOLD_CYCLES;
            end
            else if (sink_stall_en)
                n = pick_gap();
            else
                n = 0;
            if (n == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic send_sample(input logic [DATA_W-1:0] value);
        int n;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n = src_gap_en ? pick_gap() : 0;
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // sender stops until every owed result has left the block
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] span, input mode_t op,
                              input logic [2:0] pad);
        wait_drained();
        write_reg(REG_WINDOW_LEN, span);
        write_reg(REG_MODE, {pad, op});
        settings_used++;
    endtask

    initial
    begin : stimulus
        int       sent;
        int       phase;
        int       n;
        logic [CFG_W-1:0] span;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_WINDOW_LEN;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (10) @(negedge clk);
        rst_n     <= 1'b1;

        // reset settings: sum over 16, wraps on overflow
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        // average during warm-up, negative truncation toward zero
        set_config(5'd16, MODE_AVG, 3'd0);
        send_sample(-32'sd7);
        send_sample(-32'sd8);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        // zero length acts as one
        set_config(5'd0, MODE_MAX, 3'd0);
        send_sample(32'd5);
        send_sample(-32'sd5);
        // length above the store saturates
        set_config(5'd31, MODE_MIN, 3'd7);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        set_config(5'd1, MODE_SUM, 3'd0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd0);
        // growing the window brings older samples back
        set_config(5'd16, MODE_SUM, 3'd0);
        send_sample(32'd1);
        set_config(5'd16, MODE_MAX, 3'd0);
        send_sample(32'h8000_0000);
        set_config(5'd2, MODE_MIN, 3'd0);
        send_sample(32'h7FFF_FFFF);
        set_config(5'd16, MODE_AVG, 3'd0);
        send_sample(32'h8000_0000);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase++;
            case ($urandom_range(0, 5))
                0:       span = 5'd0;
                1:       span = 5'd1;
                2:       span = 5'd16;
                3:       span = 5'd31;
                default: span = CFG_W'($urandom_range(0, 31));
            endcase
            set_config(span, mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            // every fourth phase runs back to back
            sink_stall_en = (phase % 4 != 1);
            src_gap_en    = (phase % 4 != 1);
            n = $urandom_range(10, 60);
            if (phase == 3)
            begin
                src_gap_en    = 1'b0;
                sink_hold_req = 1'b1;
                n = 60;
            end
            repeat (n)
            begin
                send_sample(pick_sample());
                sent++;
            end
        end

        wait_drained();
        repeat (80) @(negedge clk);
        $display("%0d samples in, %0d results out, %0d register settings incl. lengths 0/1/16/31",
                 n_samples, n_results, settings_used);
        $display("all four modes, warm-up, overflow extremes, long output hold-off, sender pauses");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/swa_pkg.sv
rtl/swa_div.sv
rtl/sliding_window_aggregate_core.sv
bench/swa_checker.sv
bench/tb_top.sv
